// File: src/rsbm_pkg.sv
// Shared widths, defaults and operation codes for the ring slot buffer manager.
package rsbm_pkg;

  // Default number of storage slots.
  localparam int unsigned SlotsDef = 256;

  // Fixed field widths of the request and response transactions.
  localparam int unsigned OpW    = 2;
  localparam int unsigned IdxW   = 16;
  localparam int unsigned SlotW  = 8;
  localparam int unsigned CountW = 9;

  // One memory entry holds the occupancy bit above the sequence index.
  localparam int unsigned EntW = IdxW + 1;

  // Operation codes carried by a request.
  typedef enum logic [OpW-1:0] {
    OP_STORE  = 2'd0,
    OP_FETCH  = 2'd1,
    OP_REMOVE = 2'd2,
    OP_CLEAR  = 2'd3
  } op_e;

endpackage

// File: src/rsbm_if.sv
// Request and response channel interfaces of the ring slot buffer manager.
interface rsbm_req_if;
  logic                       valid;
  logic                       ready;
  logic [rsbm_pkg::OpW-1:0]   operation;
  logic [rsbm_pkg::IdxW-1:0]  seq_index;

  modport source (output valid, output operation, output seq_index, input ready);
  modport sink   (input valid, input operation, input seq_index, output ready);
endinterface

interface rsbm_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [rsbm_pkg::SlotW-1:0]   slot;
  logic [rsbm_pkg::IdxW-1:0]    assigned_index;
  logic                         found;
  logic [rsbm_pkg::CountW-1:0]  occupied_count;

  modport source (output valid, output slot, output assigned_index, output found,
                  output occupied_count, input ready);
  modport sink   (input valid, input slot, input assigned_index, input found,
                  input occupied_count, output ready);
endinterface

// File: src/ring_slot_buffer_manager.sv
// One transaction is in work at a time: store, fetch and remove pass the scan, finish
// and response states, a clear the clear and response states, before the next is taken.
// Throughput is set by the single-port slot memory, which is scanned one entry per cycle.
// A finished response waits in the output register while the next request is taken.
// Reset (rst_ni low, asynchronous) starts a clearing pass over every entry of the slot
// memory, during which no request is accepted; a clear request runs the same pass.
module ring_slot_buffer_manager #(
  parameter int unsigned Slots = rsbm_pkg::SlotsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  rsbm_req_if.sink    req_i,
  rsbm_rsp_if.source  rsp_o
);

  localparam int unsigned AW   = (Slots > 1) ? $clog2(Slots) : 1;
  localparam int unsigned CW   = $clog2(Slots + 1);
  localparam int unsigned IW   = rsbm_pkg::IdxW;
  localparam int unsigned EW   = rsbm_pkg::EntW;
  localparam int unsigned SW   = rsbm_pkg::SlotW;
  localparam int unsigned NW   = rsbm_pkg::CountW;
  localparam logic [AW-1:0] LastSlot = AW'(Slots - 1);
  localparam logic [CW-1:0] SlotsC   = CW'(Slots);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH,
    ST_CLEAR,
    ST_RESP
  } state_e;

  state_e            state_q;
  rsbm_pkg::op_e     op_q;
  logic [IW-1:0]     want_q;
  logic [AW-1:0]     addr_q;
  logic [CW-1:0]     cnt_q;
  logic [CW-1:0]     len_q;
  logic              rd_vld_q;
  logic [AW-1:0]     rd_addr_q;
  logic              hit_q;
  logic [AW-1:0]     hit_slot_q;
  logic              hit_occ_q;
  logic              best_vld_q;
  logic [AW-1:0]     best_slot_q;
  logic [IW-1:0]     best_age_q;
  logic [IW-1:0]     last_idx_q;
  logic [AW-1:0]     last_sent_q;
  logic [CW-1:0]     total_q;
  logic              clr_rsp_q;
  logic [AW-1:0]     res_slot_q;
  logic [IW-1:0]     res_idx_q;
  logic              res_found_q;
  logic              rsp_valid_q;
  logic [SW-1:0]     rsp_slot_q;
  logic [IW-1:0]     rsp_idx_q;
  logic              rsp_found_q;
  logic [NW-1:0]     rsp_count_q;

  // Slot memory: occupancy bit over sequence index, one read or write per cycle.
  logic [EW-1:0]     mem_q [Slots];
  logic [EW-1:0]     rdata_q;
  logic              mem_re;
  logic [AW-1:0]     mem_ra;
  logic              mem_we;
  logic [AW-1:0]     mem_wa;
  logic [EW-1:0]     mem_wd;

  // Shared compare unit signals.
  logic              rd_occ;
  logic [IW-1:0]     rd_idx;
  logic [IW-1:0]     age;
  logic              cmp_hit;
  logic              older;
  logic [AW-1:0]     store_slot;
  logic [IW-1:0]     next_idx;

  function automatic logic [AW-1:0] next_slot(input logic [AW-1:0] a);
    logic [AW-1:0] r;
    r = (a == LastSlot) ? '0 : a + AW'(1);
    return r;
  endfunction

  assign req_i.ready = (state_q == ST_IDLE);

  assign rsp_o.valid          = rsp_valid_q;
  assign rsp_o.slot           = rsp_slot_q;
  assign rsp_o.assigned_index = rsp_idx_q;
  assign rsp_o.found          = rsp_found_q;
  assign rsp_o.occupied_count = rsp_count_q;

  // Compare unit: one subtract and compare on each entry read back from memory.
  always_comb begin
    rd_occ     = rdata_q[EW-1];
    rd_idx     = rdata_q[IW-1:0];
    age        = last_idx_q - rd_idx;
    older      = 1'b0;
    next_idx   = last_idx_q + IW'(1);
    store_slot = hit_q ? hit_slot_q : best_slot_q;
    case (op_q)
      rsbm_pkg::OP_STORE: begin
        cmp_hit = !rd_occ;
        older   = !best_vld_q || (age > best_age_q);
      end
      rsbm_pkg::OP_FETCH:  cmp_hit = rd_occ;
      rsbm_pkg::OP_REMOVE: cmp_hit = (rd_idx == want_q);
      default:             cmp_hit = 1'b0;
    endcase
  end

  // Memory port control.
  always_comb begin
    mem_re = (state_q == ST_SCAN) && (cnt_q != len_q);
    mem_ra = addr_q;
    mem_we = 1'b0;
    mem_wa = addr_q;
    mem_wd = '0;
    if (state_q == ST_CLEAR) begin
      mem_we = 1'b1;
    end else if (state_q == ST_FINISH) begin
      if (op_q == rsbm_pkg::OP_STORE) begin
        mem_we = 1'b1;
        mem_wa = store_slot;
        mem_wd = {1'b1, next_idx};
      end else if (op_q == rsbm_pkg::OP_REMOVE && hit_q) begin
        mem_we = 1'b1;
        mem_wa = hit_slot_q;
        mem_wd = {1'b0, want_q};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rdata_q <= mem_q[mem_ra];
    end
  end

  // Sequencer with state and registered response.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      op_q        <= rsbm_pkg::OP_CLEAR;
      want_q      <= '0;
      addr_q      <= '0;
      cnt_q       <= '0;
      len_q       <= '0;
      rd_vld_q    <= 1'b0;
      rd_addr_q   <= '0;
      hit_q       <= 1'b0;
      hit_slot_q  <= '0;
      hit_occ_q   <= 1'b0;
      best_vld_q  <= 1'b0;
      best_slot_q <= '0;
      best_age_q  <= '0;
      last_idx_q  <= '0;
      last_sent_q <= LastSlot;
      total_q     <= '0;
      clr_rsp_q   <= 1'b0;
      res_slot_q  <= '0;
      res_idx_q   <= '0;
      res_found_q <= 1'b0;
      rsp_valid_q <= 1'b0;
      rsp_slot_q  <= '0;
      rsp_idx_q   <= '0;
      rsp_found_q <= 1'b0;
      rsp_count_q <= '0;
    end else begin
      // The response state loads the next response itself when the current one is taken.
      if (rsp_valid_q && rsp_o.ready && (state_q != ST_RESP)) begin
        rsp_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (req_i.valid) begin
            op_q       <= rsbm_pkg::op_e'(req_i.operation);
            want_q     <= req_i.seq_index;
            hit_q      <= 1'b0;
            best_vld_q <= 1'b0;
            rd_vld_q   <= 1'b0;
            cnt_q      <= '0;
            if (rsbm_pkg::op_e'(req_i.operation) == rsbm_pkg::OP_CLEAR) begin
              state_q     <= ST_CLEAR;
              addr_q      <= '0;
              clr_rsp_q   <= 1'b1;
              last_idx_q  <= '0;
              last_sent_q <= LastSlot;
              total_q     <= '0;
            end else if (rsbm_pkg::op_e'(req_i.operation) == rsbm_pkg::OP_FETCH) begin
              state_q <= ST_SCAN;
              addr_q  <= next_slot(last_sent_q);
              len_q   <= SlotsC - CW'(1);
            end else begin
              state_q <= ST_SCAN;
              addr_q  <= '0;
              len_q   <= SlotsC;
            end
          end
        end
        ST_SCAN: begin
          rd_vld_q  <= mem_re;
          rd_addr_q <= addr_q;
          if (mem_re) begin
            addr_q <= next_slot(addr_q);
            cnt_q  <= cnt_q + CW'(1);
          end
          if (rd_vld_q) begin
            if (cmp_hit && !hit_q) begin
              hit_q      <= 1'b1;
              hit_slot_q <= rd_addr_q;
              hit_occ_q  <= rd_occ;
            end
            if (op_q == rsbm_pkg::OP_STORE && older) begin
              best_vld_q  <= 1'b1;
              best_slot_q <= rd_addr_q;
              best_age_q  <= age;
            end
          end
          if (!mem_re && !rd_vld_q) begin
            state_q <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          state_q <= ST_RESP;
          case (op_q)
            rsbm_pkg::OP_STORE: begin
              res_slot_q  <= store_slot;
              res_idx_q   <= next_idx;
              res_found_q <= 1'b1;
              last_idx_q  <= next_idx;
              total_q     <= total_q + CW'(hit_q);
            end
            rsbm_pkg::OP_FETCH: begin
              res_slot_q  <= hit_q ? hit_slot_q : '0;
              res_idx_q   <= '0;
              res_found_q <= hit_q;
              if (hit_q) begin
                last_sent_q <= hit_slot_q;
              end
            end
            rsbm_pkg::OP_REMOVE: begin
              res_slot_q  <= hit_q ? hit_slot_q : '0;
              res_idx_q   <= '0;
              res_found_q <= hit_q;
              total_q     <= total_q - CW'(hit_q && hit_occ_q);
            end
            default: begin
              res_slot_q  <= '0;
              res_idx_q   <= '0;
              res_found_q <= 1'b0;
            end
          endcase
        end
        ST_CLEAR: begin
          addr_q <= addr_q + AW'(1);
          cnt_q  <= cnt_q + CW'(1);
          if (cnt_q == SlotsC - CW'(1)) begin
            clr_rsp_q   <= 1'b0;
            res_slot_q  <= '0;
            res_idx_q   <= '0;
            res_found_q <= 1'b0;
            state_q     <= clr_rsp_q ? ST_RESP : ST_IDLE;
          end
        end
        ST_RESP: begin
          if (!rsp_valid_q || rsp_o.ready) begin
            rsp_valid_q <= 1'b1;
            rsp_slot_q  <= SW'(res_slot_q);
            rsp_idx_q   <= res_idx_q;
            rsp_found_q <= res_found_q;
            rsp_count_q <= NW'(total_q);
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

// File: src/rsbm_checker.sv
// Port-level checker for the ring slot buffer manager and its bind statement.
module rsbm_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         req_valid_i,
  input logic                         req_ready_i,
  input logic [rsbm_pkg::OpW-1:0]     req_operation_i,
  input logic                         rsp_valid_i,
  input logic                         rsp_ready_i,
  input logic [rsbm_pkg::IdxW-1:0]    rsp_assigned_index_i,
  input logic                         rsp_found_i,
  input logic [rsbm_pkg::CountW-1:0]  rsp_occupied_count_i
);

  // Operation of the most recent accepted request transaction.
  rsbm_pkg::op_e op_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_q <= rsbm_pkg::OP_CLEAR;
    end else if (req_valid_i && req_ready_i) begin
      op_q <= rsbm_pkg::op_e'(req_operation_i);
    end
  end

  // A pending response holds until it is taken.
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i)
    else $error("response dropped before it was taken");

  // Only one request is worked on at a time.
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_i |=> !req_ready_i)
    else $error("request accepted while another is in work");

  // A store always reports a slot and a nonzero occupancy.
  a_store_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rsp_valid_i) && op_q == rsbm_pkg::OP_STORE
      |-> rsp_found_i && rsp_occupied_count_i != '0)
    else $error("store response without a slot");

  // A clear leaves nothing occupied and reports nothing found.
  a_clear_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rsp_valid_i) && op_q == rsbm_pkg::OP_CLEAR
      |-> !rsp_found_i && rsp_occupied_count_i == '0 && rsp_assigned_index_i == '0)
    else $error("clear response not empty");

endmodule

bind ring_slot_buffer_manager rsbm_checker u_rsbm_checker (
  .clk_i                (clk_i),
  .rst_ni               (rst_ni),
  .req_valid_i          (req_i.valid),
  .req_ready_i          (req_i.ready),
  .req_operation_i      (req_i.operation),
  .rsp_valid_i          (rsp_o.valid),
  .rsp_ready_i          (rsp_o.ready),
  .rsp_assigned_index_i (rsp_o.assigned_index),
  .rsp_found_i          (rsp_o.found),
  .rsp_occupied_count_i (rsp_o.occupied_count)
);
